// ----- rtl/mtg_pkg.sv -----
// Shared types and constants of the MT19937 generator.
package mtg_pkg;

    localparam int ADDR_W = 10;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [31:0]       word_t;

    localparam addr_t STATE_WORDS  = 10'd624;
    localparam addr_t LAST_WORD    = 10'd623;
    localparam addr_t TWIST_OFFSET = 10'd397;
    localparam addr_t WRAP_OFFSET  = 10'd227;

    localparam word_t INIT_MULT = 32'd1812433253;
    localparam word_t TWIST_XOR = 32'h9908_b0df;
    localparam word_t TEMPER_B  = 32'h9d2c_5680;
    localparam word_t TEMPER_C  = 32'hefc6_0000;
    localparam word_t LOW_BITS  = 32'h7fff_ffff;
    localparam word_t HIGH_BIT  = 32'h8000_0000;

    localparam logic REQ_GENERATE = 1'b0;
    localparam logic REQ_RESEED   = 1'b1;

    typedef enum logic [1:0] {
        ALU_SEED_MUL,
        ALU_SEED_ADD,
        ALU_TWIST,
        ALU_TEMPER
    } alu_op_t;

    typedef struct packed {
        logic    en;
        alu_op_t op;
        addr_t   idx;
    } alu_ctrl_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        logic  re;
        addr_t raddr_a;
        addr_t raddr_b;
    } ram_ctrl_t;

endpackage

// ----- rtl/mtg_state_ram.sv -----
// State memory of 624 words with one write port and two registered read ports.
module mtg_state_ram (
    input  logic              clk,
    input  mtg_pkg::ram_ctrl_t ctrl,
    input  mtg_pkg::word_t    wdata,
    output mtg_pkg::word_t    rdata_a,
    output mtg_pkg::word_t    rdata_b
);
    import mtg_pkg::*;

    word_t mem [0:STATE_WORDS-1];
    word_t rdata_a_reg;
    word_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[ctrl.waddr] <= wdata;
        end
        if (ctrl.re)
        begin
            rdata_a_reg <= mem[ctrl.raddr_a];
            rdata_b_reg <= mem[ctrl.raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- rtl/mtg_alu.sv -----
// Shared arithmetic unit: seeding multiply and add, twist mix and tempering.
module mtg_alu (
    input  logic                clk,
    input  mtg_pkg::alu_ctrl_t  ctrl,
    input  mtg_pkg::word_t      a,
    input  mtg_pkg::word_t      b,
    input  mtg_pkg::word_t      c,
    output mtg_pkg::word_t      result
);
    import mtg_pkg::*;

    word_t result_reg;
    word_t result_next;

    function automatic word_t twist_mix(word_t cur, word_t nxt, word_t far);
        word_t y;
        word_t m;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        m = (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
        return far ^ m;
    endfunction

    function automatic word_t temper(word_t w);
        word_t y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    always_comb
    begin
        unique case (ctrl.op)
            ALU_SEED_MUL: result_next = INIT_MULT * (a ^ (a >> 30));
            ALU_SEED_ADD: result_next = a + {{(32-ADDR_W){1'b0}}, ctrl.idx};
            ALU_TWIST:    result_next = twist_mix(a, b, c);
            ALU_TEMPER:   result_next = temper(a);
            default:      result_next = a;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- rtl/mersenne_twister_generator.sv -----
// Top level of the MT19937 generator: request sequencer, output register and assertions.
// A generate beat keeps the request side stalled until it is through: it passes the read,
// temper and output states, and the output state registers its result. The first generate
// after a reseed, and every 624th one after that, first twists the state: a pre-read and
// capture of word zero, then the read, mix and write states for each word through the
// single shared arithmetic unit and the two-read, one-write state memory. A reseed beat
// gives no result and keeps the request side stalled while it writes all 624 words. A
// result that the receiver holds off keeps the next result, and with it the request side,
// waiting for as long as the hold lasts. Until the first reseed, generate beats go straight
// to the output state and return zero words without touching the memory, and no clearing
// pass follows reset.
module mersenne_twister_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic [31:0] seed_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] random_word
);
    import mtg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GEN_RD,
        S_GEN_TMP,
        S_OUT,
        S_TW_PRE,
        S_TW_CUR,
        S_TW_RD,
        S_TW_MIX,
        S_TW_WR,
        S_SD_W0,
        S_SD_MUL,
        S_SD_ADD,
        S_SD_WR
    } state_t;

    state_t    state_reg;
    addr_t     idx_reg;
    addr_t     k_reg;
    word_t     cur_reg;
    logic      seeded_reg;
    logic      rsp_valid_reg;
    word_t     word_reg;

    logic      req_fire;
    addr_t     next_addr;
    addr_t     far_addr;
    ram_ctrl_t ram_ctrl;
    word_t     ram_wdata;
    word_t     rd_a;
    word_t     rd_b;
    alu_ctrl_t alu_ctrl;
    word_t     alu_a;
    word_t     alu_res;

    assign req_stall   = (state_reg != S_IDLE);
    assign req_fire    = req_valid && !req_stall;
    assign rsp_valid   = rsp_valid_reg;
    assign random_word = word_reg;

    assign next_addr = (k_reg == LAST_WORD) ? '0 : k_reg + 10'd1;
    assign far_addr  = (k_reg < WRAP_OFFSET) ? k_reg + TWIST_OFFSET : k_reg - WRAP_OFFSET;

    always_comb
    begin
        ram_ctrl  = '0;
        ram_wdata = alu_res;
        alu_ctrl  = '{en: 1'b0, op: ALU_TEMPER, idx: k_reg};
        alu_a     = rd_a;
        unique case (state_reg)
            S_GEN_RD:
            begin
                ram_ctrl.re      = 1'b1;
                ram_ctrl.raddr_a = idx_reg;
            end
            S_GEN_TMP:
            begin
                alu_ctrl.en = 1'b1;
                alu_ctrl.op = ALU_TEMPER;
            end
            S_TW_PRE:
            begin
                ram_ctrl.re      = 1'b1;
                ram_ctrl.raddr_a = '0;
            end
            S_TW_RD:
            begin
                ram_ctrl.re      = 1'b1;
                ram_ctrl.raddr_a = next_addr;
                ram_ctrl.raddr_b = far_addr;
            end
            S_TW_MIX:
            begin
                alu_ctrl.en = 1'b1;
                alu_ctrl.op = ALU_TWIST;
                alu_a       = cur_reg;
            end
            S_TW_WR, S_SD_WR:
            begin
                ram_ctrl.we    = 1'b1;
                ram_ctrl.waddr = k_reg;
            end
            S_SD_W0:
            begin
                ram_ctrl.we    = 1'b1;
                ram_ctrl.waddr = '0;
                ram_wdata      = cur_reg;
            end
            S_SD_MUL:
            begin
                alu_ctrl.en = 1'b1;
                alu_ctrl.op = ALU_SEED_MUL;
                alu_a       = cur_reg;
            end
            S_SD_ADD:
            begin
                alu_ctrl.en = 1'b1;
                alu_ctrl.op = ALU_SEED_ADD;
                alu_a       = alu_res;
            end
            default:
            begin
            end
        endcase
    end

    mtg_state_ram u_ram (
        .clk     (clk),
        .ctrl    (ram_ctrl),
        .wdata   (ram_wdata),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    mtg_alu u_alu (
        .clk    (clk),
        .ctrl   (alu_ctrl),
        .a      (alu_a),
        .b      (rd_a),
        .c      (rd_b),
        .result (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= STATE_WORDS;
            k_reg         <= '0;
            cur_reg       <= '0;
            seeded_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            word_reg      <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && state_reg != S_OUT)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        if (req_type == REQ_RESEED)
                        begin
                            cur_reg   <= seed_value;
                            state_reg <= S_SD_W0;
                        end
                        else if (!seeded_reg)
                        begin
                            state_reg <= S_OUT;
                        end
                        else if (idx_reg == STATE_WORDS)
                        begin
                            state_reg <= S_TW_PRE;
                        end
                        else
                        begin
                            state_reg <= S_GEN_RD;
                        end
                    end
                end
                S_GEN_RD:
                begin
                    state_reg <= S_GEN_TMP;
                end
                S_GEN_TMP:
                begin
                    idx_reg   <= idx_reg + 10'd1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        word_reg      <= seeded_reg ? alu_res : '0;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_TW_PRE:
                begin
                    state_reg <= S_TW_CUR;
                end
                S_TW_CUR:
                begin
                    cur_reg   <= rd_a;
                    k_reg     <= '0;
                    state_reg <= S_TW_RD;
                end
                S_TW_RD:
                begin
                    state_reg <= S_TW_MIX;
                end
                S_TW_MIX:
                begin
                    cur_reg   <= rd_a;
                    state_reg <= S_TW_WR;
                end
                S_TW_WR:
                begin
                    if (k_reg == LAST_WORD)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_GEN_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 10'd1;
                        state_reg <= S_TW_RD;
                    end
                end
                S_SD_W0:
                begin
                    k_reg     <= 10'd1;
                    state_reg <= S_SD_MUL;
                end
                S_SD_MUL:
                begin
                    state_reg <= S_SD_ADD;
                end
                S_SD_ADD:
                begin
                    state_reg <= S_SD_WR;
                end
                S_SD_WR:
                begin
                    cur_reg <= alu_res;
                    if (k_reg == LAST_WORD)
                    begin
                        idx_reg    <= STATE_WORDS;
                        seeded_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 10'd1;
                        state_reg <= S_SD_MUL;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // Before the first reseed every delivered word is zero.
    a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!seeded_reg && rsp_valid_reg) |-> (word_reg == '0))
        else $error("nonzero word delivered before the first reseed");

    // The read index never passes the end of the state.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= STATE_WORDS)
        else $error("word index beyond the state size");

    // A twist starts only when the whole state has been consumed.
    a_twist_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TW_PRE) |-> (idx_reg == STATE_WORDS))
        else $error("twist started with words left");

    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> req_stall)
        else $error("request side ready right after an accepted beat");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench of the MT19937 generator with its own word predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtg_pkg::*;

    localparam int NWORDS = STATE_WORDS;
    localparam int OFFSET = TWIST_OFFSET;
    localparam int RANDOM_BEATS = 430;
    localparam int HOLD_AFTER_WORDS = 50;
    localparam int HOLD_CYCLES = 240;
    localparam int SETTLE_CYCLES = 2000;
    localparam int QUIET_LIMIT = 20000;

    typedef struct {
        logic  kind;
        word_t seed;
        bit    drain_first;
    } mt_request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        req_type = REQ_GENERATE;
    logic [31:0] seed_value = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [31:0] random_word;

    mt_request_t pending[$];
    word_t       expected_words[$];
    word_t       mt_state[NWORDS] = '{default: '0};
    int unsigned mt_pos = NWORDS;
    int          total_beats = 1;
    int          beats_in = 0;
    int          words_out = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          quiet_cycles = 0;
    int          fails = 0;

    mersenne_twister_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .seed_value (seed_value),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .random_word(random_word)
    );

    function automatic void seed_state(word_t s);
        word_t p;
        mt_state[0] = s;
        for (int k = 1; k < NWORDS; k++)
        begin
            p = mt_state[k-1];
            mt_state[k] = INIT_MULT * (p ^ (p >> 30)) + word_t'(k);
        end
        mt_pos = NWORDS;
    endfunction

    function automatic void twist_state();
        word_t y;
        for (int k = 0; k < NWORDS; k++)
        begin
            y = (mt_state[k] & HIGH_BIT) | (mt_state[(k + 1) % NWORDS] & LOW_BITS);
            mt_state[k] = mt_state[(k + OFFSET) % NWORDS] ^ (y >> 1)
                        ^ (y[0] ? TWIST_XOR : 32'd0);
        end
        mt_pos = 0;
    endfunction

    function automatic word_t draw_word();
        word_t y;
        if (mt_pos >= NWORDS)
            twist_state();
        y = mt_state[mt_pos];
        y ^= y >> 11;
        y ^= (y << 7) & TEMPER_B;
        y ^= (y << 15) & TEMPER_C;
        y ^= y >> 18;
        mt_pos++;
        return y;
    endfunction

    function automatic int idle_phase();
        return (beats_in * 3) / total_beats;
    endfunction

    task automatic queue_beat(logic kind, word_t seed);
        mt_request_t r;
        r.kind = kind;
        r.seed = seed;
        r.drain_first = 1'b0;
        pending.push_back(r);
    endtask

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        mt_request_t r;
        bit          idle;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_type <= REQ_GENERATE;
            seed_value <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                if (req_type == REQ_RESEED)
                    seed_state(seed_value);
                else
                    expected_words.push_back(draw_word());
                beats_in++;
            end
            if (!req_valid || !req_stall)
            begin
                case (idle_phase())
                    0: idle = ($urandom_range(99) < 17);
                    1: idle = ($urandom_range(99) < 58);
                    default: idle = 1'b0;
                endcase
                if (pending.size() != 0 && !idle
                    && !(pending[0].drain_first && expected_words.size() != 0))
                begin
                    r = pending.pop_front();
                    req_valid <= 1'b1;
                    req_type <= r.kind;
                    seed_value <= r.seed;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        word_t w;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("random_word: unexpected beat %h with no expectation", random_word);
                    fails++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (random_word !== w)
                    begin
                        $error("random_word: expected %h, actual %h", w, random_word);
                        fails++;
                    end
                end
                words_out++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && words_out >= HOLD_AFTER_WORDS)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (idle_phase())
                    0: rsp_stall <= ($urandom_range(99) < 58);
                    1: rsp_stall <= ($urandom_range(99) < 17);
                    default: rsp_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[mersenne_twister_generator] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int    n_directed;
        int    run_len;
        word_t s;

        // Before any reseed the state is all zeros and every word is zero.
        queue_beat(REQ_GENERATE, 32'h0000_0000);
        queue_beat(REQ_GENERATE, 32'hffff_ffff);
        queue_beat(REQ_GENERATE, 32'h5555_aaaa);
        queue_beat(REQ_RESEED, 32'h0000_0000);
        queue_beat(REQ_GENERATE, 32'hffff_ffff);
        queue_beat(REQ_GENERATE, 32'h0000_0000);
        queue_beat(REQ_RESEED, 32'hffff_ffff);
        queue_beat(REQ_GENERATE, 32'h0000_0000);
        queue_beat(REQ_GENERATE, 32'hffff_ffff);
        queue_beat(REQ_RESEED, 32'd5489);
        queue_beat(REQ_GENERATE, 32'haaaa_5555);
        queue_beat(REQ_GENERATE, 32'h1234_5678);
        queue_beat(REQ_GENERATE, 32'h8765_4321);
        queue_beat(REQ_RESEED, 32'h8000_0001);
        queue_beat(REQ_RESEED, 32'h7fff_fffe);
        queue_beat(REQ_GENERATE, 32'hffff_ffff);
        queue_beat(REQ_GENERATE, 32'h0000_0000);
        queue_beat(REQ_RESEED, 32'h0000_0001);
        queue_beat(REQ_GENERATE, 32'h8000_0000);
        n_directed = pending.size();

        while (pending.size() < n_directed + RANDOM_BEATS)
        begin
            case ($urandom_range(7))
                0: s = 32'h0000_0000;
                1: s = 32'hffff_ffff;
                default: s = $urandom();
            endcase
            queue_beat(REQ_RESEED, s);
            if ($urandom_range(9) == 0)
                run_len = 0;
            else
                run_len = $urandom_range(1, 40);
            repeat (run_len) queue_beat(REQ_GENERATE, $urandom());
        end

        total_beats = pending.size();
        pending[n_directed].drain_first = 1'b1;
        pending[total_beats / 3].drain_first = 1'b1;
        pending[(2 * total_beats) / 3].drain_first = 1'b1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fails == 0 && expected_words.size() == 0)
            $display("[mersenne_twister_generator] OK");
        else
            $display("[mersenne_twister_generator] ERROR");
        $finish;
    end
endmodule
